>>> design/htq_pkg.sv
package htq_pkg;

    // Field widths of the channels and the configuration register
    localparam int W_MODE   = 1;
    localparam int W_INDEX  = 15;
    localparam int W_HEIGHT = 16;
    localparam int W_POS    = 24;
    localparam int W_TILES  = 8;

    // Default build parameters
    localparam int HTQ_MAX_TILES     = 128;
    localparam int HTQ_FRACTION_BITS = 8;

    // Register reset value
    localparam logic [W_TILES-1:0] TILES_RESET = W_TILES'(128);

    // Saturation limits of the height result
    localparam logic [W_HEIGHT-1:0] H_SAT_MAX = 16'h7FFF;
    localparam logic [W_HEIGHT-1:0] H_SAT_MIN = 16'h8000;

    typedef enum logic [W_MODE-1:0] {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_READ,
        S_LAST,
        S_DIFF,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

endpackage

>>> design/htq_in_if.sv
interface htq_in_if import htq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [W_MODE-1:0]          mode;
    logic [W_INDEX-1:0]         sample_index;
    logic signed [W_HEIGHT-1:0] sample_height;
    logic signed [W_POS-1:0]    pos_x;
    logic signed [W_POS-1:0]    pos_z;

    modport source (output valid, mode, sample_index, sample_height, pos_x, pos_z,
                    input ready);
    modport sink   (input valid, mode, sample_index, sample_height, pos_x, pos_z,
                    output ready);
endinterface

>>> design/htq_out_if.sv
interface htq_out_if import htq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [W_HEIGHT-1:0] height;
    logic                       outside_grid;

    modport source (output valid, height, outside_grid, input ready);
    modport sink   (input valid, height, outside_grid, output ready);
endinterface

>>> design/htq_ram.sv
module htq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/heightmap_triangle_height_query.sv
// Terrain height lookup. The grid holds (T+1) x (T+1) signed 16-bit samples in
// one single-port RAM, T being tiles_per_side clamped to 1..MAX_TILES. A write
// transaction (mode 0) stores one sample at its row-major index and
// gives no result; indexes past the grid depth are dropped. A query transaction
// (mode 1) takes a signed X,Z position with FRACTION_BITS fraction bits and
// returns the height interpolated on the lower or upper triangle of its cell.
// An in-grid query occupies the block while it makes the four corner reads on
// the single grid RAM port and passes the difference, multiply and sum stages;
// a position outside the grid skips them and returns zero with outside_grid
// set. The result sits in an output register, so the next transaction is
// taken while it waits. Samples must be written before they are queried; the
// grid is not cleared by reset.
module heightmap_triangle_height_query
    import htq_pkg::*;
#(
    parameter int MAX_TILES     = HTQ_MAX_TILES,
    parameter int FRACTION_BITS = HTQ_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    htq_in_if.sink             i_in,
    htq_out_if.source          o_out,
    input  logic               i_cfg_wr_en,
    input  logic [W_TILES-1:0] i_cfg_wr_data
);

    localparam int FB         = FRACTION_BITS;
    localparam int GRID_DEPTH = (MAX_TILES + 1) * (MAX_TILES + 1);
    localparam int AW         = $clog2(GRID_DEPTH);
    localparam int TW         = $clog2(MAX_TILES + 2);     // holds T+1
    localparam int CW         = ((TW + FB) > (W_POS - 1) ? (TW + FB) : (W_POS - 1)) + 1;
    localparam int DW         = W_HEIGHT + 1;               // corner difference
    localparam int PW         = DW + FB + 2;                // weighted product
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    t_state r_state, n_state;

    logic [W_TILES-1:0] r_tiles;
    logic [TW-1:0]      t_eff;
    logic [TW-1:0]      t_plus1;

    // query geometry
    logic [CW-1:0] pmx, pmz, lim;
    logic          outside;
    logic [TW-1:0] cx, cz;

    logic [TW-1:0] r_cx, r_cz, r_nx, r_nz;
    logic [FB-1:0] r_fx, r_fz;
    logic [AW-1:0] r_row0, r_row1;
    logic [2*TW-1:0] row0_full, row1_full;

    logic [1:0] r_cnt;
    logic       r_rd_pend;
    logic [1:0] r_rd_sel;
    logic signed [W_HEIGHT-1:0] r_h [4];

    logic                       lower;
    logic [FB:0]                fsum;
    logic [FB:0]                r_wa, r_wb;
    logic signed [DW-1:0]       r_da, r_db;
    logic signed [W_HEIGHT-1:0] r_base;
    logic signed [PW-1:0]       prod_a, prod_b, r_pa, r_pb;
    logic signed [PW:0]         sum_ab, sum_sh;
    logic signed [PW+1:0]       h_full;
    logic                       h_fits;
    logic [W_HEIGHT-1:0]        h_sat;

    logic [W_HEIGHT-1:0] r_res_height;
    logic                r_res_outside;
    logic                r_o_valid;
    logic [W_HEIGHT-1:0] r_o_height;
    logic                r_o_outside;

    logic          in_acc;
    logic          out_free;
    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [W_HEIGHT-1:0] ram_rdata;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles <= TILES_RESET;
        end else if (i_cfg_wr_en) begin
            r_tiles <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_tiles == '0) begin
            t_eff = TW'(1);
        end else if (32'(r_tiles) > MAX_TILES) begin
            t_eff = TW'(MAX_TILES);
        end else begin
            t_eff = TW'(r_tiles);
        end
        t_plus1 = t_eff + TW'(1);
    end

    // ---------------- input decode ----------------
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;

    assign pmx = CW'(i_in.pos_x[W_POS-2:0]);
    assign pmz = CW'(i_in.pos_z[W_POS-2:0]);
    assign lim = CW'(t_eff) << FB;
    assign outside = i_in.pos_x[W_POS-1] || i_in.pos_z[W_POS-1] || (pmx > lim) || (pmz > lim);
    assign cx = TW'(pmx >> FB);
    assign cz = TW'(pmz >> FB);

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_READ);
            r_cnt     <= (r_state == S_READ) ? r_cnt + 2'd1 : 2'd0;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        ram_en   = 1'b0;
        ram_we   = 1'b0;
        ram_addr = AW'(i_in.sample_index);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (t_mode'(i_in.mode) == MODE_WRITE) begin
                        ram_en = 32'(i_in.sample_index) < GRID_DEPTH;
                        ram_we = 1'b1;
                    end else begin
                        n_state = outside ? S_DONE : S_ROW;
                    end
                end
            end
            S_ROW:  n_state = S_READ;
            S_READ: begin
                ram_en = 1'b1;
                case (r_cnt)
                    2'd0:    ram_addr = r_row0 + AW'(r_cx);
                    2'd1:    ram_addr = r_row0 + AW'(r_nx);
                    2'd2:    ram_addr = r_row1 + AW'(r_cx);
                    default: ram_addr = r_row1 + AW'(r_nx);
                endcase
                if (r_cnt == 2'd3) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_DIFF;
            S_DIFF: n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    htq_ram #(
        .WIDTH (W_HEIGHT),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.sample_height),
        .o_rdata (ram_rdata)
    );

    // ---------------- datapath ----------------
    assign row0_full = r_cz * t_plus1;
    assign row1_full = r_nz * t_plus1;

    assign fsum  = {1'b0, r_fx} + {1'b0, r_fz};
    assign lower = fsum < ONE;

    assign prod_a = r_da * $signed({1'b0, r_wa});
    assign prod_b = r_db * $signed({1'b0, r_wb});

    // arithmetic shift floors the weighted sum
    assign sum_ab = (PW + 1)'(r_pa) + (PW + 1)'(r_pb);
    assign sum_sh = sum_ab >>> FB;
    assign h_full = (PW + 2)'(sum_sh) + (PW + 2)'(r_base);
    assign h_fits = (h_full[PW+1:W_HEIGHT-1] == '0) || (h_full[PW+1:W_HEIGHT-1] == '1);
    assign h_sat  = h_fits ? h_full[W_HEIGHT-1:0] : (h_full[PW+1] ? H_SAT_MIN : H_SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_cx          <= cx;
            r_cz          <= cz;
            r_nx          <= (cx < t_eff) ? cx + TW'(1) : t_eff;
            r_nz          <= (cz < t_eff) ? cz + TW'(1) : t_eff;
            r_fx          <= i_in.pos_x[FB-1:0];
            r_fz          <= i_in.pos_z[FB-1:0];
            r_res_height  <= '0;
            r_res_outside <= outside;
        end
        if (r_state == S_ROW) begin
            r_row0 <= AW'(row0_full);
            r_row1 <= AW'(row1_full);
        end
        if (r_rd_pend) begin
            r_h[r_rd_sel] <= $signed(ram_rdata);
        end
        r_rd_sel <= r_cnt;
        // corners: 0 = (x,z), 1 = (x+1,z), 2 = (x,z+1), 3 = (x+1,z+1)
        if (r_state == S_DIFF) begin
            if (lower) begin
                r_wa   <= {1'b0, r_fx};
                r_wb   <= {1'b0, r_fz};
                r_da   <= DW'(r_h[1]) - DW'(r_h[0]);
                r_db   <= DW'(r_h[2]) - DW'(r_h[0]);
                r_base <= r_h[0];
            end else begin
                r_wa   <= ONE - {1'b0, r_fx};
                r_wb   <= ONE - {1'b0, r_fz};
                r_da   <= DW'(r_h[2]) - DW'(r_h[3]);
                r_db   <= DW'(r_h[1]) - DW'(r_h[3]);
                r_base <= r_h[3];
            end
        end
        if (r_state == S_MUL) begin
            r_pa <= prod_a;
            r_pb <= prod_b;
        end
        if (r_state == S_SUM) begin
            r_res_height <= h_sat;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_height  <= r_res_height;
            r_o_outside <= r_res_outside;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.height       = r_o_height;
    assign o_out.outside_grid = r_o_outside;

endmodule

>>> design/htq_chk.sv
module htq_chk
    import htq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [W_MODE-1:0]   i_in_mode,
    input logic [W_POS-1:0]    i_in_pos_x,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [W_HEIGHT-1:0] i_out_height,
    input logic                i_out_outside
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // stalled result must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_height) && $stable(i_out_outside))
        else $error("result changed while stalled");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_outside |-> i_out_height == '0)
        else $error("outside result with nonzero height");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_mode'(i_in_mode) == MODE_WRITE && !i_out_valid |=> !i_out_valid)
        else $error("write transaction produced a result");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_mode'(i_in_mode) == MODE_QUERY |=> !i_in_ready)
        else $error("input ready while query in flight");

    a_neg_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && t_mode'(i_in_mode) == MODE_QUERY && i_in_pos_x[W_POS-1] && !i_out_valid
        |-> ##2 (i_out_valid && i_out_outside))
        else $error("negative X not flagged outside");

endmodule

bind heightmap_triangle_height_query htq_chk u_htq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_mode     (i_in.mode),
    .i_in_pos_x    (i_in.pos_x),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_height  (o_out.height),
    .i_out_outside (o_out.outside_grid)
);
